FILE: design/c8eng_pkg.sv
// shared types, opcode codes and font table for the chip-8 instruction engine
package c8eng_pkg;

	localparam int FRM_AW = 6;

	localparam logic [2:0] REQ_EXEC  = 3'd0;
	localparam logic [2:0] REQ_KEY   = 3'd1;
	localparam logic [2:0] REQ_TICK  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_ROW   = 3'd4;

	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SEQI = 4'h3;
	localparam logic [3:0] GRP_SNEI = 4'h4;
	localparam logic [3:0] GRP_SEQ  = 4'h5;
	localparam logic [3:0] GRP_LDI  = 4'h6;
	localparam logic [3:0] GRP_ADDI = 4'h7;
	localparam logic [3:0] GRP_ALU  = 4'h8;
	localparam logic [3:0] GRP_SNE  = 4'h9;
	localparam logic [3:0] GRP_LDIX = 4'hA;
	localparam logic [3:0] GRP_JPV  = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;
	localparam logic [3:0] GRP_DRW  = 4'hD;
	localparam logic [3:0] GRP_KEY  = 4'hE;
	localparam logic [3:0] GRP_MISC = 4'hF;

	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [7:0] NN_CLS  = 8'hE0;
	localparam logic [7:0] NN_RET  = 8'hEE;
	localparam logic [7:0] NN_SKP  = 8'h9E;
	localparam logic [7:0] NN_SKNP = 8'hA1;
	localparam logic [7:0] NN_LDDT = 8'h07;
	localparam logic [7:0] NN_WKEY = 8'h0A;
	localparam logic [7:0] NN_SDT  = 8'h15;
	localparam logic [7:0] NN_SST  = 8'h18;
	localparam logic [7:0] NN_ADDX = 8'h1E;
	localparam logic [7:0] NN_FONT = 8'h29;
	localparam logic [7:0] NN_BCD  = 8'h33;
	localparam logic [7:0] NN_STR  = 8'h55;
	localparam logic [7:0] NN_LDR  = 8'h65;

	localparam logic [11:0] PROG_START = 12'h200;
	localparam logic [15:0] FONT_BASE  = 16'h0050;
	localparam int          FONT_LEN   = 80;

	localparam logic [7:0] FONT [FONT_LEN] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef struct packed {
		logic              we;
		logic              clear;
		logic [FRM_AW-1:0] waddr;
		logic [FRM_AW-1:0] raddr;
	} frm_ctl_t;

	// decimal digit of v: 0 hundreds, 1 tens, 2 ones
	function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
		logic [1:0]  h;
		logic [7:0]  r;
		logic [15:0] p;
		logic [3:0]  t;
		logic [7:0]  o;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		r = v - (8'(h) * 8'd100);
		p = 16'(r) * 16'd205;
		t = p[14:11];
		o = r - (8'(t) * 8'd10);
		case (sel)
			2'd0: bcd_digit = 8'(h);
			2'd1: bcd_digit = 8'(t);
			default: bcd_digit = o;
		endcase
	endfunction

endpackage

FILE: design/c8eng_frame.sv
// frame store: one row per entry, per-row valid bits for instant clear
module c8eng_frame #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  c8eng_pkg::frm_ctl_t      ctl,
	input  logic [SCREEN_WIDTH-1:0]  wdata,
	output logic [SCREEN_WIDTH-1:0]  rdata
);
	import c8eng_pkg::*;

	localparam int YW   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int ROWS = 1 << YW;

	logic [SCREEN_WIDTH-1:0] rows_mem [ROWS];
	logic [ROWS-1:0]         valid_q;
	logic [SCREEN_WIDTH-1:0] rraw_q;
	logic                    rvalid_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			rows_mem[ctl.waddr[YW-1:0]] <= wdata;
		end
		rraw_q <= rows_mem[ctl.raddr[YW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[ctl.raddr[YW-1:0]];
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (ctl.we) begin
				valid_q[ctl.waddr[YW-1:0]] <= 1'b1;
			end
		end
	end

	assign rdata = rvalid_q ? rraw_q : '0;

endmodule

FILE: design/chip8_instruction_engine_top.sv
// CHIP-8 core: one request beat in, one status beat out. After reset a clearing
// pass writes all MEM_BYTES (4096 by default) bytes of main memory, loading the
// font, and no beat is taken during it. An instruction steps through two fetch
// reads, the vx and vy reads and execute before its status beat; sprite draws,
// FX33, FX55 and FX65 add states per drawn row or per byte moved. Every fetch,
// sprite row and block move goes through the main memory one byte per access.
module chip8_instruction_engine_top #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32,
	parameter int MEM_BYTES     = 4096,
	parameter int STACK_DEPTH   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // key_index, mem_addr, mem_data, row_index, random_byte
	input  logic [2:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // prog_counter, halted, waiting_for_key, sound_on, screen_bits
);
	import c8eng_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int XW = $clog2(SCREEN_WIDTH);
	localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [6:0] HEIGHT = 7'(SCREEN_HEIGHT);
	localparam logic [SW-1:0] SP_LAST = SW'(STACK_DEPTH - 1);

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_F1   = 4'd2;
	localparam logic [3:0] ST_F2   = 4'd3;
	localparam logic [3:0] ST_RX   = 4'd4;
	localparam logic [3:0] ST_RY   = 4'd5;
	localparam logic [3:0] ST_EXE  = 4'd6;
	localparam logic [3:0] ST_DRD  = 4'd7;
	localparam logic [3:0] ST_DWR  = 4'd8;
	localparam logic [3:0] ST_BCD  = 4'd9;
	localparam logic [3:0] ST_STR  = 4'd10;
	localparam logic [3:0] ST_LRD  = 4'd11;
	localparam logic [3:0] ST_LWR  = 4'd12;
	localparam logic [3:0] ST_ROW  = 4'd13;
	localparam logic [3:0] ST_FIN  = 4'd14;

	// input fields
	logic [2:0]  in_req;
	logic [3:0]  in_key;
	logic [11:0] in_addr;
	logic [7:0]  in_data;
	logic [4:0]  in_row;
	logic [7:0]  in_rnd;
	logic        s_acc;

	assign in_req  = s_tuser;
	assign in_key  = s_tdata[3:0];
	assign in_addr = s_tdata[15:4];
	assign in_data = s_tdata[23:16];
	assign in_row  = s_tdata[28:24];
	assign in_rnd  = s_tdata[36:29];

	logic [3:0]    state_q;
	logic [AW-1:0] clr_cnt_q;
	logic [11:0]   pc_q;
	logic [15:0]   idx_q;
	logic [SW-1:0] sp_q;
	logic [15:0]   key_q;
	logic [7:0]    dt_q;
	logic [7:0]    snd_q;
	logic          halt_q;
	logic          waiting_q;
	logic [7:0]    v_q [16];
	logic [11:0]   stack_q [STACK_DEPTH];
	logic [7:0]    hi_q;
	logic [15:0]   op_q;
	logic [7:0]    vx_q;
	logic [7:0]    vy_q;
	logic [7:0]    rnd_q;
	logic [6:0]    row_q;
	logic [XW-1:0] x0_q;
	logic [3:0]    cnt_q;
	logic          hit_q;
	logic [63:0]   scr_q;
	logic          m_valid_q;
	logic [79:0]   m_data_q;

	logic [3:0]  grp, op_x, op_y, op_n;
	logic [7:0]  op_nn;
	logic [11:0] op_nnn;

	assign grp    = op_q[15:12];
	assign op_x   = op_q[11:8];
	assign op_y   = op_q[7:4];
	assign op_n   = op_q[3:0];
	assign op_nn  = op_q[7:0];
	assign op_nnn = op_q[11:0];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// wrap tables for the sprite start point
	logic [XW-1:0] xmod_tab [256];
	logic [YW-1:0] ymod_tab [256];
	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign xmod_tab[g] = XW'(g % SCREEN_WIDTH);
		assign ymod_tab[g] = YW'(g % SCREEN_HEIGHT);
	end

	// register file read port
	logic [3:0] rd_idx;
	logic [7:0] reg_rd;
	always_comb begin
		case (state_q)
			ST_RX:   rd_idx = op_x;
			ST_RY:   rd_idx = op_y;
			ST_STR:  rd_idx = cnt_q;
			default: rd_idx = 4'd0;
		endcase
	end
	assign reg_rd = v_q[rd_idx];

	// lowest pressed key
	logic [3:0] key_first;
	always_comb begin
		key_first = 4'd0;
		for (int k = 15; k >= 0; k--) begin
			if (key_q[k]) begin
				key_first = 4'(k);
			end
		end
	end

	// state after the execute cycle
	logic [3:0] exe_next;
	always_comb begin
		exe_next = ST_FIN;
		if (grp == GRP_DRW && op_n != 4'd0) begin
			exe_next = ST_DRD;
		end else if (grp == GRP_MISC && op_nn == NN_BCD) begin
			exe_next = ST_BCD;
		end else if (grp == GRP_MISC && op_nn == NN_STR) begin
			exe_next = ST_STR;
		end else if (grp == GRP_MISC && op_nn == NN_LDR) begin
			exe_next = ST_LRD;
		end
	end

	// main memory
	logic [7:0]    main_mem [MEM_BYTES];
	logic [7:0]    mem_rdata;
	logic [AW-1:0] mraddr;
	logic          mwe;
	logic [AW-1:0] mwaddr;
	logic [7:0]    mwdata;
	logic [15:0]   idx_off;
	logic [AW-1:0] font_off;

	assign idx_off  = idx_q + 16'(cnt_q);
	assign font_off = clr_cnt_q - AW'(FONT_BASE);

	always_comb begin
		case (state_q)
			ST_F1:   mraddr = AW'(pc_q + 12'd1);
			ST_DRD:  mraddr = idx_off[AW-1:0];
			ST_LRD:  mraddr = idx_off[AW-1:0];
			default: mraddr = pc_q[AW-1:0];
		endcase
	end

	always_comb begin
		mwe    = 1'b0;
		mwaddr = idx_off[AW-1:0];
		mwdata = reg_rd;
		case (state_q)
			ST_INIT: begin
				mwe    = 1'b1;
				mwaddr = clr_cnt_q;
				mwdata = 8'd0;
				if (clr_cnt_q >= AW'(FONT_BASE) && font_off < AW'(FONT_LEN)) begin
					mwdata = FONT[font_off[6:0]];
				end
			end
			ST_IDLE: begin
				mwe    = s_acc && (in_req == REQ_WRITE);
				mwaddr = in_addr[AW-1:0];
				mwdata = in_data;
			end
			ST_BCD: begin
				mwe    = 1'b1;
				mwdata = bcd_digit(vx_q, cnt_q[1:0]);
			end
			ST_STR: begin
				mwe = 1'b1;
			end
			default: begin
				mwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mwe) begin
			main_mem[mwaddr] <= mwdata;
		end
		mem_rdata <= main_mem[mraddr];
	end

	// frame store
	frm_ctl_t                frm_ctl;
	logic [SCREEN_WIDTH-1:0] frm_rdata;
	logic [SCREEN_WIDTH-1:0] spr_mask;
	logic [SCREEN_WIDTH+7:0] spr_wide;
	logic [SCREEN_WIDTH+63:0] row_wide;

	assign spr_wide = {mem_rdata, {SCREEN_WIDTH{1'b0}}} >> x0_q;
	assign spr_mask = spr_wide[SCREEN_WIDTH+7:8];
	assign row_wide = {frm_rdata, 64'd0};

	always_comb begin
		frm_ctl.we    = (state_q == ST_DWR);
		frm_ctl.clear = (state_q == ST_EXE) && (grp == GRP_SYS) && (op_nn == NN_CLS);
		frm_ctl.waddr = row_q[FRM_AW-1:0];
		frm_ctl.raddr = (state_q == ST_IDLE) ? FRM_AW'(in_row) : row_q[FRM_AW-1:0];
	end

	c8eng_frame #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_frame (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (frm_ctl),
		.wdata (frm_rdata ^ spr_mask),
		.rdata (frm_rdata)
	);

	// register file write ports, vf port applied last
	logic       rwe;
	logic [3:0] rwidx;
	logic [7:0] rwdata;
	logic       fwe;
	logic [7:0] fwdata;
	logic [8:0] add_sum;

	assign add_sum = {1'b0, vx_q} + {1'b0, vy_q};

	always_comb begin
		rwe    = 1'b0;
		rwidx  = op_x;
		rwdata = vy_q;
		fwe    = 1'b0;
		fwdata = 8'd0;
		case (state_q)
			ST_EXE: begin
				case (grp)
					GRP_LDI: begin
						rwe    = 1'b1;
						rwdata = op_nn;
					end
					GRP_ADDI: begin
						rwe    = 1'b1;
						rwdata = vx_q + op_nn;
					end
					GRP_ALU: begin
						case (op_n)
							ALU_MOV: begin
								rwe    = 1'b1;
								rwdata = vy_q;
							end
							ALU_OR: begin
								rwe    = 1'b1;
								rwdata = vx_q | vy_q;
							end
							ALU_AND: begin
								rwe    = 1'b1;
								rwdata = vx_q & vy_q;
							end
							ALU_XOR: begin
								rwe    = 1'b1;
								rwdata = vx_q ^ vy_q;
							end
							ALU_ADD: begin
								rwe    = 1'b1;
								rwdata = add_sum[7:0];
								fwe    = 1'b1;
								fwdata = 8'(add_sum[8]);
							end
							ALU_SUB: begin
								rwe    = 1'b1;
								rwdata = vx_q - vy_q;
								fwe    = 1'b1;
								fwdata = 8'(vx_q >= vy_q);
							end
							ALU_SHR: begin
								rwe    = 1'b1;
								rwdata = {1'b0, vx_q[7:1]};
								fwe    = 1'b1;
								fwdata = 8'(vx_q[0]);
							end
							ALU_SUBN: begin
								rwe    = 1'b1;
								rwdata = vy_q - vx_q;
								fwe    = 1'b1;
								fwdata = 8'(vy_q >= vx_q);
							end
							ALU_SHL: begin
								rwe    = 1'b1;
								rwdata = {vx_q[6:0], 1'b0};
								fwe    = 1'b1;
								fwdata = 8'(vx_q[7]);
							end
							default: begin
								rwe = 1'b0;
							end
						endcase
					end
					GRP_RND: begin
						rwe    = 1'b1;
						rwdata = rnd_q & op_nn;
					end
					GRP_DRW: begin
						fwe = (op_n == 4'd0);
					end
					GRP_MISC: begin
						if (op_nn == NN_LDDT) begin
							rwe    = 1'b1;
							rwdata = dt_q;
						end else if (op_nn == NN_WKEY) begin
							rwe    = |key_q;
							rwdata = 8'(key_first);
						end
					end
					default: begin
						rwe = 1'b0;
					end
				endcase
			end
			ST_DRD: begin
				fwe    = (cnt_q == op_n) || (row_q >= HEIGHT);
				fwdata = 8'(hit_q);
			end
			ST_LWR: begin
				rwe    = 1'b1;
				rwidx  = cnt_q;
				rwdata = mem_rdata;
			end
			default: begin
				rwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				v_q[i] <= 8'd0;
			end
		end else begin
			if (rwe) begin
				v_q[rwidx] <= rwdata;
			end
			if (fwe) begin
				v_q[15] <= fwdata;
			end
		end
	end

	// call stack
	logic [SW-1:0] sp_inc, sp_dec;
	assign sp_inc = (sp_q == SP_LAST) ? '0 : sp_q + SW'(1);
	assign sp_dec = (sp_q == '0) ? SP_LAST : sp_q - SW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				stack_q[i] <= 12'd0;
			end
		end else if (state_q == ST_EXE && grp == GRP_CALL) begin
			stack_q[sp_q] <= pc_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			clr_cnt_q <= '0;
			pc_q      <= PROG_START;
			idx_q     <= 16'd0;
			sp_q      <= '0;
			key_q     <= 16'd0;
			dt_q      <= 8'd0;
			snd_q     <= 8'd0;
			halt_q    <= 1'b0;
			waiting_q <= 1'b0;
			hi_q      <= 8'd0;
			op_q      <= 16'd0;
			vx_q      <= 8'd0;
			vy_q      <= 8'd0;
			rnd_q     <= 8'd0;
			row_q     <= 7'd0;
			x0_q      <= '0;
			cnt_q     <= 4'd0;
			hit_q     <= 1'b0;
			scr_q     <= 64'd0;
			m_valid_q <= 1'b0;
			m_data_q  <= 80'd0;
		end else begin
			if (m_valid_q && m_tready && state_q != ST_FIN) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MEM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						rnd_q     <= in_rnd;
						row_q     <= 7'(in_row);
						waiting_q <= 1'b0;
						scr_q     <= 64'd0;
						case (in_req)
							REQ_EXEC: state_q <= halt_q ? ST_FIN : ST_F1;
							REQ_KEY: begin
								key_q   <= key_q ^ (16'd1 << in_key);
								state_q <= ST_FIN;
							end
							REQ_TICK: begin
								if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
								if (snd_q != 8'd0) snd_q <= snd_q - 8'd1;
								state_q <= ST_FIN;
							end
							REQ_ROW: state_q <= ST_ROW;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_F1: begin
					hi_q    <= mem_rdata;
					state_q <= ST_F2;
				end
				ST_F2: begin
					op_q    <= {hi_q, mem_rdata};
					pc_q    <= pc_q + 12'd2;
					state_q <= ST_RX;
				end
				ST_RX: begin
					vx_q    <= reg_rd;
					state_q <= ST_RY;
				end
				ST_RY: begin
					vy_q    <= reg_rd;
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= exe_next;
					cnt_q   <= 4'd0;
					case (grp)
						GRP_SYS: begin
							if (op_nn == NN_RET) begin
								sp_q <= sp_dec;
								pc_q <= stack_q[sp_dec];
							end else if (op_nn != NN_CLS) begin
								halt_q <= 1'b1;
							end
						end
						GRP_JP: pc_q <= op_nnn;
						GRP_CALL: begin
							sp_q <= sp_inc;
							pc_q <= op_nnn;
						end
						GRP_SEQI: if (vx_q == op_nn) pc_q <= pc_q + 12'd2;
						GRP_SNEI: if (vx_q != op_nn) pc_q <= pc_q + 12'd2;
						GRP_SEQ:  if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
						GRP_SNE:  if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
						GRP_LDIX: idx_q <= 16'(op_nnn);
						GRP_JPV:  pc_q <= op_nnn + 12'(reg_rd);
						GRP_DRW: begin
							if (op_n != 4'd0) begin
								x0_q  <= xmod_tab[vx_q];
								row_q <= 7'(ymod_tab[vy_q]);
								hit_q <= 1'b0;
							end
						end
						GRP_KEY: begin
							if (op_nn == NN_SKP) begin
								if (key_q[vx_q[3:0]]) pc_q <= pc_q + 12'd2;
							end else if (op_nn == NN_SKNP) begin
								if (!key_q[vx_q[3:0]]) pc_q <= pc_q + 12'd2;
							end else begin
								halt_q <= 1'b1;
							end
						end
						GRP_MISC: begin
							case (op_nn)
								NN_LDDT, NN_BCD, NN_STR, NN_LDR: ;
								NN_WKEY: begin
									if (key_q == 16'd0) begin
										pc_q      <= pc_q - 12'd2;
										waiting_q <= 1'b1;
									end
								end
								NN_SDT:  dt_q <= vx_q;
								NN_SST:  snd_q <= vx_q;
								NN_ADDX: idx_q <= idx_q + 16'(vx_q);
								NN_FONT: idx_q <= FONT_BASE + 16'({vx_q[3:0], 2'b00})
									+ 16'(vx_q[3:0]);
								default: halt_q <= 1'b1;
							endcase
						end
						default: ;
					endcase
				end
				ST_DRD: begin
					if (cnt_q == op_n || row_q >= HEIGHT) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DWR;
					end
				end
				ST_DWR: begin
					hit_q   <= hit_q | (|(frm_rdata & spr_mask));
					cnt_q   <= cnt_q + 4'd1;
					row_q   <= row_q + 7'd1;
					state_q <= ST_DRD;
				end
				ST_BCD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd2) begin
						state_q <= ST_FIN;
					end
				end
				ST_STR: begin
					if (cnt_q == op_x) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_LRD: state_q <= ST_LWR;
				ST_LWR: begin
					if (cnt_q == op_x) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q   <= cnt_q + 4'd1;
						state_q <= ST_LRD;
					end
				end
				ST_ROW: begin
					if (row_q < HEIGHT) begin
						scr_q <= row_wide[SCREEN_WIDTH+63 -: 64];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {1'b0, scr_q, snd_q != 8'd0, waiting_q, halt_q, pc_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !m_valid_q)
		else $error("result beat during memory clearing pass");

	a_halt_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && in_req == REQ_EXEC && halt_q) |=> (state_q == ST_FIN))
		else $error("halted core started an instruction");

	a_draw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DWR) |-> (cnt_q < op_n && row_q < HEIGHT))
		else $error("sprite row past count or screen bottom");

	a_block_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STR || state_q == ST_LWR) |-> (cnt_q <= op_x))
		else $error("register block move past vx");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && m_valid_q && !m_tready) |=> (state_q == ST_FIN && m_valid_q))
		else $error("result overwrote an unaccepted beat");

endmodule
